FILE: hdl/sri_pkg.sv
// ----------------------------------------------------------------------------
// sri_pkg
// Shared types, widths and helpers for the segment/rectangle intersect block.
// ----------------------------------------------------------------------------
package sri_pkg;

    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 15;
    localparam int DIFF_W     = COORD_W + 1;   // a - b of two coordinates
    localparam int FAR_W      = COORD_W + 2;   // a - (b + size)
    localparam int NUM_W      = 37;            // holds any product difference
    localparam int FIFO_DEPTH = 4;

    typedef logic signed [NUM_W-1:0] t_num;

    // one classified query, as handed from front to back
    typedef struct packed {
        logic signed [DIFF_W-1:0] dxs;   // bx - ax
        logic signed [DIFF_W-1:0] dys;   // by - ay
        logic signed [DIFF_W-1:0] oxl;   // ax - x
        logic signed [DIFF_W-1:0] oyt;   // ay - y
        logic signed [FAR_W-1:0]  oxr;   // ax - (x + w)
        logic signed [FAR_W-1:0]  oyb;   // ay - (y + h)
        logic [SIZE_W-1:0]        w;
        logic [SIZE_W-1:0]        h;
        logic                     par_v; // vertical sides parallel or degenerate
        logic                     par_h; // horizontal sides parallel or degenerate
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // num/den lies in [0,1], den nonzero
    function automatic logic in_unit(t_num num, t_num den);
        logic res;
        res = 1'b0;
        if (den > 0) begin
            res = (num >= 0) && (num <= den);
        end else if (den < 0) begin
            res = (num <= 0) && (num >= den);
        end
        return res;
    endfunction

endpackage

FILE: hdl/sri_front.sv
// ----------------------------------------------------------------------------
// sri_front
// Input register: takes a query word, forms coordinate differences and flags
// sides that are parallel to the segment or have zero length.
// ----------------------------------------------------------------------------
module sri_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [sri_pkg::COORD_W-1:0]  i_seg_ax,
    input  logic signed [sri_pkg::COORD_W-1:0]  i_seg_ay,
    input  logic signed [sri_pkg::COORD_W-1:0]  i_seg_bx,
    input  logic signed [sri_pkg::COORD_W-1:0]  i_seg_by,
    input  logic signed [sri_pkg::COORD_W-1:0]  i_rect_x,
    input  logic signed [sri_pkg::COORD_W-1:0]  i_rect_y,
    input  logic        [sri_pkg::SIZE_W-1:0]   i_rect_w,
    input  logic        [sri_pkg::SIZE_W-1:0]   i_rect_h,
    output logic                                o_push,
    output sri_pkg::t_job                       o_job,
    input  sri_pkg::t_q_stat                    i_q_stat
);
    import sri_pkg::*;

    logic                     r_valid;
    t_job                     r_job;
    t_job                     n_job;
    logic signed [DIFF_W-1:0] n_x2;
    logic signed [DIFF_W-1:0] n_y2;

    assign o_push     = r_valid && !i_q_stat.full;
    assign o_in_ready = !r_valid || !i_q_stat.full;
    assign o_job      = r_job;

    always_comb begin
        // far edges, exact (no wrap)
        n_x2 = DIFF_W'(i_rect_x) + $signed({2'b00, i_rect_w});
        n_y2 = DIFF_W'(i_rect_y) + $signed({2'b00, i_rect_h});

        n_job.dxs   = DIFF_W'(i_seg_bx) - DIFF_W'(i_seg_ax);
        n_job.dys   = DIFF_W'(i_seg_by) - DIFF_W'(i_seg_ay);
        n_job.oxl   = DIFF_W'(i_seg_ax) - DIFF_W'(i_rect_x);
        n_job.oyt   = DIFF_W'(i_seg_ay) - DIFF_W'(i_rect_y);
        n_job.oxr   = FAR_W'(i_seg_ax) - FAR_W'(n_x2);
        n_job.oyb   = FAR_W'(i_seg_ay) - FAR_W'(n_y2);
        n_job.w     = i_rect_w;
        n_job.h     = i_rect_h;
        n_job.par_v = (i_rect_h == '0) || (i_seg_bx == i_seg_ax);
        n_job.par_h = (i_rect_w == '0) || (i_seg_by == i_seg_ay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_job <= n_job;
        end
    end

endmodule

FILE: hdl/sri_fifo.sv
// ----------------------------------------------------------------------------
// sri_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module sri_fifo #(
    parameter int DEPTH = sri_pkg::FIFO_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  sri_pkg::t_job                i_job,
    input  logic                         i_pop,
    output sri_pkg::t_job                o_job,
    output sri_pkg::t_q_stat             o_stat,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    import sri_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_count      = r_cnt;
    assign o_job        = r_mem[r_rd];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

FILE: hdl/sri_back.sv
// ----------------------------------------------------------------------------
// sri_back
// Two-stage evaluator: cross products, then range checks into the output
// register.
// ----------------------------------------------------------------------------
module sri_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sri_pkg::t_job     i_job,
    input  sri_pkg::t_q_stat  i_q_stat,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_hit,
    output logic              o_hit_left,
    output logic              o_hit_right,
    output logic              o_hit_top,
    output logic              o_hit_bottom
);
    import sri_pkg::*;

    localparam int PN_W = 2 * DIFF_W;          // near products
    localparam int PF_W = DIFF_W + FAR_W;      // far products
    localparam int PD_W = SIZE_W + 1 + DIFF_W; // denominators

    // product stage
    logic                   r_a_valid;
    logic signed [PN_W-1:0] r_p_xt;   // dxs * oyt
    logic signed [PN_W-1:0] r_p_yl;   // dys * oxl
    logic signed [PF_W-1:0] r_p_xb;   // dxs * oyb
    logic signed [PF_W-1:0] r_p_yr;   // dys * oxr
    logic signed [PD_W-1:0] r_den_v;  // h * dxs
    logic signed [PD_W-1:0] r_den_h;  // w * dys
    logic [3:0]             r_na_ok;  // left, right, top, bottom
    logic                   r_par_v;
    logic                   r_par_h;
    logic [3:0]             n_na_ok;

    // output stage
    logic                   r_b_valid;
    logic [3:0]             r_side;
    logic [3:0]             n_side;
    t_num                   n_dv;
    t_num                   n_dh;

    logic                   b_ready;
    logic                   a_ready;

    assign b_ready = !r_b_valid || i_out_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_pop   = a_ready && !i_q_stat.empty;

    // with the side length positive it cancels out of the first parameter
    always_comb begin
        n_na_ok[0] = in_unit(-NUM_W'(i_job.oxl), NUM_W'(i_job.dxs));
        n_na_ok[1] = in_unit(-NUM_W'(i_job.oxr), NUM_W'(i_job.dxs));
        n_na_ok[2] = in_unit(NUM_W'(i_job.oyt), -NUM_W'(i_job.dys));
        n_na_ok[3] = in_unit(NUM_W'(i_job.oyb), -NUM_W'(i_job.dys));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= !i_q_stat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p_xt  <= i_job.dxs * i_job.oyt;
            r_p_yl  <= i_job.dys * i_job.oxl;
            r_p_xb  <= i_job.dxs * i_job.oyb;
            r_p_yr  <= i_job.dys * i_job.oxr;
            r_den_v <= $signed({1'b0, i_job.h}) * i_job.dxs;
            r_den_h <= $signed({1'b0, i_job.w}) * i_job.dys;
            r_na_ok <= n_na_ok;
            r_par_v <= i_job.par_v;
            r_par_h <= i_job.par_h;
        end
    end

    always_comb begin
        n_dv = NUM_W'(r_den_v);
        n_dh = -NUM_W'(r_den_h);
        n_side[0] = !r_par_v && r_na_ok[0]
                    && in_unit(NUM_W'(r_p_xt) - NUM_W'(r_p_yl), n_dv);
        n_side[1] = !r_par_v && r_na_ok[1]
                    && in_unit(NUM_W'(r_p_xt) - NUM_W'(r_p_yr), n_dv);
        n_side[2] = !r_par_h && r_na_ok[2]
                    && in_unit(NUM_W'(r_p_xt) - NUM_W'(r_p_yl), n_dh);
        n_side[3] = !r_par_h && r_na_ok[3]
                    && in_unit(NUM_W'(r_p_xb) - NUM_W'(r_p_yl), n_dh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_side <= n_side;
        end
    end

    assign o_out_valid  = r_b_valid;
    assign o_hit_left   = r_side[0];
    assign o_hit_right  = r_side[1];
    assign o_hit_top    = r_side[2];
    assign o_hit_bottom = r_side[3];
    assign o_hit        = |r_side;

endmodule

FILE: hdl/segment_rectangle_intersect.sv
// ----------------------------------------------------------------------------
// segment_rectangle_intersect
// Tests a line segment against the four sides of an axis-aligned rectangle.
// ----------------------------------------------------------------------------
//  channel  handshake                  word
//  -------  -------------------------  -----------------------------------
//  in       i_in_valid / o_in_ready    i_seg_ax..i_seg_by, i_rect_x..i_rect_h
//  out      o_out_valid / i_out_ready  o_hit, o_hit_left/right/top/bottom
//
//  One word per cycle sustained while the output is not stalled. Stages:
//  input register, queue, product stage (six multipliers, up to 17x18),
//  range check into the output register. Queue depth is DEPTH words.
//  Reset clears all valid flags and queue pointers; no clearing pass.
//  An output stall backs up through the back end and queue; the front keeps
//  taking words until the queue is full.
// ----------------------------------------------------------------------------
module segment_rectangle_intersect #(
    parameter int DEPTH = sri_pkg::FIFO_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [sri_pkg::COORD_W-1:0]  i_seg_ax,
    input  logic signed [sri_pkg::COORD_W-1:0]  i_seg_ay,
    input  logic signed [sri_pkg::COORD_W-1:0]  i_seg_bx,
    input  logic signed [sri_pkg::COORD_W-1:0]  i_seg_by,
    input  logic signed [sri_pkg::COORD_W-1:0]  i_rect_x,
    input  logic signed [sri_pkg::COORD_W-1:0]  i_rect_y,
    input  logic        [sri_pkg::SIZE_W-1:0]   i_rect_w,
    input  logic        [sri_pkg::SIZE_W-1:0]   i_rect_h,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_hit,
    output logic                                o_hit_left,
    output logic                                o_hit_right,
    output logic                                o_hit_top,
    output logic                                o_hit_bottom
);
    import sri_pkg::*;

    logic                       w_push;
    logic                       w_pop;
    t_job                       w_front_job;
    t_job                       w_back_job;
    t_q_stat                    w_q_stat;
    logic [$clog2(DEPTH+1)-1:0] w_q_count;

    sri_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_seg_ax   (i_seg_ax),
        .i_seg_ay   (i_seg_ay),
        .i_seg_bx   (i_seg_bx),
        .i_seg_by   (i_seg_by),
        .i_rect_x   (i_rect_x),
        .i_rect_y   (i_rect_y),
        .i_rect_w   (i_rect_w),
        .i_rect_h   (i_rect_h),
        .o_push     (w_push),
        .o_job      (w_front_job),
        .i_q_stat   (w_q_stat)
    );

    sri_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_back_job),
        .o_stat  (w_q_stat),
        .o_count (w_q_count)
    );

    sri_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_back_job),
        .i_q_stat     (w_q_stat),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hit        (o_hit),
        .o_hit_left   (o_hit_left),
        .o_hit_right  (o_hit_right),
        .o_hit_top    (o_hit_top),
        .o_hit_bottom (o_hit_bottom)
    );

    a_hit_or: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hit == (o_hit_left | o_hit_right | o_hit_top | o_hit_bottom)))
        else $error("hit flag disagrees with side flags");

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= ($clog2(DEPTH+1))'(DEPTH))
        else $error("queue count past depth");

    a_q_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.empty |-> !w_pop)
        else $error("pop from empty queue");

    a_q_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop && !w_q_stat.full) |=> (w_q_count == $past(w_q_count) + 1'b1))
        else $error("queue count missed a push");

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for segment_rectangle_intersect. A driver feeds segment/rectangle
// queries from a backlog and a monitor checks every hit word against an
// exact integer model of the four side tests. Directed corner cases come
// first, then random queries, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CW          = sri_pkg::COORD_W;
    localparam int SW          = sri_pkg::SIZE_W;
    localparam int STALL_LIMIT = 5000;
    localparam int N_RANDOM    = 1800;
    localparam int HOLD_AT     = 700;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic [SW-1:0]        w;
        logic [SW-1:0]        h;
        bit                   drain_first;  // hold off until all hits are back
    } t_query;

    typedef struct {
        bit any;
        bit left;
        bit right;
        bit top;
        bit bottom;
    } t_side_hits;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_out_ready = 1'b0;
    logic signed [CW-1:0] i_seg_ax    = '0;
    logic signed [CW-1:0] i_seg_ay    = '0;
    logic signed [CW-1:0] i_seg_bx    = '0;
    logic signed [CW-1:0] i_seg_by    = '0;
    logic signed [CW-1:0] i_rect_x    = '0;
    logic signed [CW-1:0] i_rect_y    = '0;
    logic [SW-1:0]        i_rect_w    = '0;
    logic [SW-1:0]        i_rect_h    = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_hit;
    logic                 o_hit_left;
    logic                 o_hit_right;
    logic                 o_hit_top;
    logic                 o_hit_bottom;

    t_query     query_backlog[$];
    t_side_hits pending_hits[$];
    int         n_items         = 0;
    int         sent_count      = 0;
    int         error_count     = 0;
    int         send_gap        = 0;
    int         sink_gap        = 0;
    int         hold_left       = 0;
    bit         long_hold_done  = 1'b0;
    int         stall_cycles    = 0;

    segment_rectangle_intersect dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_seg_ax     (i_seg_ax),
        .i_seg_ay     (i_seg_ay),
        .i_seg_bx     (i_seg_bx),
        .i_seg_by     (i_seg_by),
        .i_rect_x     (i_rect_x),
        .i_rect_y     (i_rect_y),
        .i_rect_w     (i_rect_w),
        .i_rect_h     (i_rect_h),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hit        (o_hit),
        .o_hit_left   (o_hit_left),
        .o_hit_right  (o_hit_right),
        .o_hit_top    (o_hit_top),
        .o_hit_bottom (o_hit_bottom)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- prediction ----------------

    // num/den in [0,1] without dividing
    function automatic bit ratio_in_unit(longint num, longint den);
        if (den > 0) return (num >= 0) && (num <= den);
        if (den < 0) return (num <= 0) && (num >= den);
        return 1'b0;
    endfunction

    function automatic bit side_crossed(longint ax, longint ay, longint bx, longint by,
                                        longint px, longint py, longint qx, longint qy);
        longint dxs, dys, dxe, dye, ox, oy, den, na, nb;
        dxs = bx - ax;
        dys = by - ay;
        dxe = qx - px;
        dye = qy - py;
        ox  = ax - px;
        oy  = ay - py;
        den = dye * dxs - dxe * dys;
        na  = dxe * oy - dye * ox;
        nb  = dxs * oy - dys * ox;
        if (den == 0) return 1'b0;   // parallel, collinear or degenerate
        return ratio_in_unit(na, den) && ratio_in_unit(nb, den);
    endfunction

    function automatic t_side_hits predict_side_hits(t_query q);
        t_side_hits s;
        longint ax, ay, bx, by, x1, y1, x2, y2;
        ax = longint'(q.ax);
        ay = longint'(q.ay);
        bx = longint'(q.bx);
        by = longint'(q.by);
        x1 = longint'(q.rx);
        y1 = longint'(q.ry);
        x2 = x1 + longint'(q.w);   // no wrap past 16 bits
        y2 = y1 + longint'(q.h);
        s.left   = side_crossed(ax, ay, bx, by, x1, y1, x1, y2);
        s.right  = side_crossed(ax, ay, bx, by, x2, y1, x2, y2);
        s.top    = side_crossed(ax, ay, bx, by, x1, y1, x2, y1);
        s.bottom = side_crossed(ax, ay, bx, by, x1, y2, x2, y2);
        s.any    = s.left | s.right | s.top | s.bottom;
        return s;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic int clamp16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int rand_near(int c, int spread);
        return clamp16(c + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic bit quiet_window(int n);
        return ((n % 300) >= 240) || (n >= n_items - 200);
    endfunction

    task automatic push_query(int ax, int ay, int bx, int by, int rx, int ry,
                              int w, int h, bit drain);
        t_query q;
        q.ax = CW'(ax);
        q.ay = CW'(ay);
        q.bx = CW'(bx);
        q.by = CW'(by);
        q.rx = CW'(rx);
        q.ry = CW'(ry);
        q.w  = SW'(w);
        q.h  = SW'(h);
        q.drain_first = drain;
        query_backlog.insert(query_backlog.size(), q);
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin : drive_proc
        logic   next_valid;
        t_query nq;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (!i_in_valid || o_in_ready) begin
                next_valid = 1'b0;
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                end else if (query_backlog.size() > 0) begin
                    if (query_backlog[0].drain_first &&
                        (i_in_valid || pending_hits.size() != 0)) begin
                        // wait for the pipe to empty
                    end else if (!quiet_window(sent_count) && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(0, 14);
                    end else begin
                        nq = query_backlog.pop_front();
                        i_seg_ax   <= nq.ax;
                        i_seg_ay   <= nq.ay;
                        i_seg_bx   <= nq.bx;
                        i_seg_by   <= nq.by;
                        i_rect_x   <= nq.rx;
                        i_rect_y   <= nq.ry;
                        i_rect_w   <= nq.w;
                        i_rect_h   <= nq.h;
                        next_valid = 1'b1;
                        sent_count <= sent_count + 1;
                    end
                end
            end
            i_in_valid <= next_valid;
        end
    end

    // ---------------- receiver ----------------

    always @(posedge i_clk) begin : sink_proc
        logic next_ready;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            next_ready = 1'b1;
            if (!long_hold_done && sent_count >= HOLD_AT) begin
                hold_left      = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left  = hold_left - 1;
                next_ready = 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap   = sink_gap - 1;
                next_ready = 1'b0;
            end else if (!quiet_window(sent_count) && $urandom_range(0, 7) == 0) begin
                sink_gap   = $urandom_range(0, 14);
                next_ready = 1'b0;
            end
            i_out_ready <= next_ready;
        end
    end

    // ---------------- monitor ----------------

    task automatic check_bit(string name, bit want, logic got);
        if (got !== want) begin
            $error("%s: expected %0b, actual %0b", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_proc
        t_query     q;
        t_side_hits want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                q.ax = i_seg_ax;
                q.ay = i_seg_ay;
                q.bx = i_seg_bx;
                q.by = i_seg_by;
                q.rx = i_rect_x;
                q.ry = i_rect_y;
                q.w  = i_rect_w;
                q.h  = i_rect_h;
                q.drain_first = 1'b0;
                pending_hits.insert(pending_hits.size(), predict_side_hits(q));
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_hits.size() == 0) begin
                    $error("unexpected hit word");
                    error_count++;
                end else begin
                    want = pending_hits.pop_front();
                    check_bit("hit",        want.any,    o_hit);
                    check_bit("hit_left",   want.left,   o_hit_left);
                    check_bit("hit_right",  want.right,  o_hit_right);
                    check_bit("hit_top",    want.top,    o_hit_top);
                    check_bit("hit_bottom", want.bottom, o_hit_bottom);
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles = stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin : main_proc
        int kind, rx, ry, w, h, ax, ay, bx, by;
        // directed: crossings, parallel, collinear, degenerate, touching, extremes
        push_query(-100, 50, 100, 50, -50, 0, 100, 100, 1'b0);
        push_query(0, -200, 0, 200, -50, -50, 100, 100, 1'b0);
        push_query(10, 10, 10, 10, 0, 0, 100, 100, 1'b0);
        push_query(-10, 5, 10, 5, 0, 0, 0, 100, 1'b0);
        push_query(5, -10, 5, 10, 0, 0, 100, 0, 1'b0);
        push_query(-10, -10, 10, 10, 0, 0, 0, 0, 1'b0);
        push_query(0, -20, 0, 200, 0, 0, 100, 100, 1'b0);
        push_query(10, 50, 90, 50, 0, 0, 100, 100, 1'b0);
        push_query(-50, -50, 0, 0, 0, 0, 100, 100, 1'b0);
        push_query(-50, 50, 0, 50, 0, 0, 100, 100, 1'b0);
        push_query(0, 0, 100, 100, 0, 0, 100, 100, 1'b0);
        push_query(-10, 100, 200, 100, 0, 0, 100, 100, 1'b0);
        push_query(10, 10, 20, 30, 0, 0, 100, 100, 1'b0);
        push_query(200, 200, 300, 400, 0, 0, 100, 100, 1'b0);
        push_query(32767, 32767, -32768, -32768, 32767, 32767, 32767, 32767, 1'b0);
        push_query(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 1'b0);
        push_query(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0);
        push_query(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, 1'b0);
        push_query(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 1'b0);
        push_query(32767, -32768, -32768, 32767, 0, 0, 32767, 32767, 1'b0);
        push_query(32767, 0, 0, 32767, 0, 0, 32767, 32767, 1'b0);

        for (int i = 0; i < N_RANDOM; i++) begin
            kind = $urandom_range(0, 9);
            rx = int'($urandom_range(0, 65535)) - 32768;
            ry = int'($urandom_range(0, 65535)) - 32768;
            if ($urandom_range(0, 3) == 0) begin
                w = $urandom_range(0, 32767);
                h = $urandom_range(0, 32767);
            end else begin
                w = $urandom_range(0, 200);
                h = $urandom_range(0, 200);
            end
            ax = rand_near(rx + w / 2, w + 50);
            ay = rand_near(ry + h / 2, h + 50);
            bx = rand_near(rx + w / 2, w + 50);
            by = rand_near(ry + h / 2, h + 50);
            if (kind <= 2) begin
                // raw noise over the whole field range
                ax = int'($urandom_range(0, 65535)) - 32768;
                ay = int'($urandom_range(0, 65535)) - 32768;
                bx = int'($urandom_range(0, 65535)) - 32768;
                by = int'($urandom_range(0, 65535)) - 32768;
            end else if (kind == 8) begin
                // axis-aligned segment, often on a side line
                if ($urandom_range(0, 1) == 1) begin
                    if ($urandom_range(0, 1) == 1) ax = clamp16(rx + w * $urandom_range(0, 1));
                    bx = ax;
                end else begin
                    if ($urandom_range(0, 1) == 1) ay = clamp16(ry + h * $urandom_range(0, 1));
                    by = ay;
                end
                if ($urandom_range(0, 7) == 0) begin
                    bx = ax;
                    by = ay;
                end
            end else if (kind == 9) begin
                // endpoint on a corner or a side
                ax = clamp16(rx + w * $urandom_range(0, 1));
                ay = clamp16(ry + (($urandom_range(0, 1) == 1) ? h : $urandom_range(0, h)));
                if ($urandom_range(0, 1) == 1) begin
                    bx = clamp16(rx + w * $urandom_range(0, 1));
                    by = clamp16(ry + h * $urandom_range(0, 1));
                end
            end
            push_query(ax, ay, bx, by, rx, ry, w, h, (i == 0) || (i == 1200));
        end
        n_items = query_backlog.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (query_backlog.size() != 0 || i_in_valid || pending_hits.size() != 0);
        repeat (20) @(posedge i_clk);

        if (pending_hits.size() != 0) begin
            $error("%0d hit words never arrived", pending_hits.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/sri_pkg.sv
hdl/sri_front.sv
hdl/sri_fifo.sv
hdl/sri_back.sv
hdl/segment_rectangle_intersect.sv
dv/tb_top.sv
